>>> sv/slg_pkg.sv
// Shared types and constants for the slew limiter, steering gate and drive scale block.
// Used by the controller, the datapath, the top level and the checker. No dependencies.
package slg_pkg;

  // Configuration port geometry.
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  // Register indexes on the configuration port.
  localparam logic [CFG_IDX_W-1:0] REG_LAT_STEP    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TURN_STEP   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_START_LEVEL = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_RUN_LEVEL   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_FULL_SCALE  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_SCALE_EN    = 3'd5;

  // Drive scale of one in Q1.15 and the reset value of the full scale error.
  localparam logic [15:0] SCALE_ONE      = 16'h8000;
  localparam logic [14:0] FULL_SCALE_RST = 15'd128;

  // The quotient of the scale division is below 2^15, one bit per step.
  localparam int DIV_STEPS = 15;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS);

  // Controller states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_PUSH
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;  // capture the item, update the kept values, seed the divider
    logic step;  // one restoring division step
    logic push;  // move the finished result into the output register
  } dp_cmd_t;

endpackage

>>> sv/slg_ctrl.sv
// Controller for the slew limiter block: sequences load, division steps and result push.
// Depends on slg_pkg for the state type, the command struct and the step count.
module slg_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic              out_ready,
  output logic              out_valid,
  output slg_pkg::dp_cmd_t  cmd
);

  slg_pkg::state_t                state_r, state_nxt;
  logic [slg_pkg::DIV_CNT_W-1:0]  cnt_r, cnt_nxt;
  logic                           out_valid_r, out_valid_nxt;

  // State, step counter and output valid registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= slg_pkg::ST_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Next state and commands.
  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    in_ready  = 1'b0;
    cmd       = '0;
    unique case (state_r)
      slg_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          cnt_nxt   = '0;
          state_nxt = slg_pkg::ST_DIV;
        end
      end
      slg_pkg::ST_DIV: begin
        cmd.step = 1'b1;
        cnt_nxt  = cnt_r + 1'b1;
        if (cnt_r == slg_pkg::DIV_CNT_W'(slg_pkg::DIV_STEPS - 1)) begin
          state_nxt = slg_pkg::ST_PUSH;
        end
      end
      slg_pkg::ST_PUSH: begin
        // The result waits here until the output register is free.
        if (!out_valid_r || out_ready) begin
          cmd.push  = 1'b1;
          state_nxt = slg_pkg::ST_IDLE;
        end
      end
      default: state_nxt = slg_pkg::ST_IDLE;
    endcase
  end

  // The output register holds its item until the receiver takes it.
  assign out_valid_nxt = cmd.push | (out_valid_r & ~out_ready);
  assign out_valid     = out_valid_r;

endmodule

>>> sv/slg_dp.sv
// Datapath for the slew limiter block: configuration registers, kept values, gate,
// serial scale divider and output register. Depends on slg_pkg for codes and commands.
module slg_dp (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [slg_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [slg_pkg::CFG_DATA_W-1:0] cfg_wdata,
  input  slg_pkg::dp_cmd_t               cmd,
  input  logic signed [15:0]             in_lateral_cmd,
  input  logic signed [15:0]             in_turn_cmd,
  input  logic signed [15:0]             in_steer_error,
  input  logic                           in_startup_phase,
  input  logic                           in_restart,
  output logic signed [15:0]             out_lateral_out,
  output logic signed [15:0]             out_turn_out,
  output logic                           out_blocked,
  output logic [15:0]                    out_drive_scale
);

  // Configuration registers.
  logic [14:0]        lat_step_r, turn_step_r, full_scale_r;
  logic signed [15:0] start_level_r, run_level_r;
  logic               scale_en_r;

  // Kept values and per-item working registers.
  logic signed [15:0] last_lat_r, last_turn_r;
  logic signed [15:0] lat_res_r, turn_res_r;
  logic               blk_r, one_r, zero_r;
  logic [14:0]        rem_r, quo_r, div_m_r;

  // Output register.
  logic signed [15:0] lat_out_r, turn_out_r;
  logic               blk_out_r;
  logic [15:0]        scale_out_r;

  // Slew limit one command against its kept value; the difference never wraps at 17 bits.
  function automatic logic signed [15:0] slew(input logic signed [15:0] kept,
                                              input logic signed [15:0] target,
                                              input logic [14:0]        lim);
    logic signed [16:0] diff;
    logic signed [16:0] lim_s;
    diff  = 17'(target) - 17'(kept);
    lim_s = $signed({2'b00, lim});
    if (diff <= lim_s && diff >= -lim_s) begin
      slew = target;
    end else if (diff > 17'sd0) begin
      slew = kept + $signed({1'b0, lim});
    end else begin
      slew = kept - $signed({1'b0, lim});
    end
  endfunction

  logic signed [15:0] lat_base, turn_base, lat_new, turn_new;
  logic signed [15:0] level;
  logic [14:0]        m_eff;
  logic               err_pos, err_big;
  logic [15:0]        rem_sh;
  logic               rem_ge;

  // Restart clears the kept values ahead of this item's step.
  always_comb begin
    lat_base  = in_restart ? 16'sd0 : last_lat_r;
    turn_base = in_restart ? 16'sd0 : last_turn_r;
    lat_new   = slew(lat_base, in_lateral_cmd, lat_step_r);
    turn_new  = slew(turn_base, in_turn_cmd, turn_step_r);
    level     = in_startup_phase ? start_level_r : run_level_r;
    m_eff     = (full_scale_r == 15'd0) ? 15'd1 : full_scale_r;
    err_pos   = in_steer_error > 16'sd0;
    err_big   = 17'(in_steer_error) >= $signed({2'b00, m_eff});
  end

  // One restoring step: the remainder stays below the divisor as long as the seed does.
  assign rem_sh = {rem_r, 1'b0};
  assign rem_ge = rem_sh >= {1'b0, div_m_r};

  // Configuration writes; indexes past the list are ignored.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lat_step_r    <= '0;
      turn_step_r   <= '0;
      start_level_r <= '0;
      run_level_r   <= '0;
      full_scale_r  <= slg_pkg::FULL_SCALE_RST;
      scale_en_r    <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        slg_pkg::REG_LAT_STEP:    lat_step_r    <= cfg_wdata[14:0];
        slg_pkg::REG_TURN_STEP:   turn_step_r   <= cfg_wdata[14:0];
        slg_pkg::REG_START_LEVEL: start_level_r <= $signed(cfg_wdata);
        slg_pkg::REG_RUN_LEVEL:   run_level_r   <= $signed(cfg_wdata);
        slg_pkg::REG_FULL_SCALE:  full_scale_r  <= cfg_wdata[14:0];
        slg_pkg::REG_SCALE_EN:    scale_en_r    <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // Kept values update as the item is taken.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_lat_r  <= '0;
      last_turn_r <= '0;
    end else if (cmd.load) begin
      last_lat_r  <= lat_new;
      last_turn_r <= turn_new;
    end
  end

  // Working registers: gate result, scale selection flags and the serial divider.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      lat_res_r  <= lat_new;
      turn_res_r <= turn_new;
      blk_r      <= in_steer_error > level;
      one_r      <= !scale_en_r || !err_pos;
      zero_r     <= err_big;
      div_m_r    <= m_eff;
      // Seed with full scale minus error; only meaningful when 0 < error < full scale.
      rem_r      <= m_eff - in_steer_error[14:0];
      quo_r      <= '0;
    end else if (cmd.step) begin
      rem_r <= rem_ge ? 15'(rem_sh - {1'b0, div_m_r}) : rem_sh[14:0];
      quo_r <= {quo_r[13:0], rem_ge};
    end
  end

  // Output register, loaded when the result is pushed.
  always_ff @(posedge clk) begin
    if (cmd.push) begin
      lat_out_r  <= lat_res_r;
      turn_out_r <= turn_res_r;
      blk_out_r  <= blk_r;
      if (blk_r || (!one_r && zero_r)) begin
        scale_out_r <= 16'd0;
      end else if (one_r) begin
        scale_out_r <= slg_pkg::SCALE_ONE;
      end else begin
        scale_out_r <= {1'b0, quo_r};
      end
    end
  end

  assign out_lateral_out = lat_out_r;
  assign out_turn_out    = turn_out_r;
  assign out_blocked     = blk_out_r;
  assign out_drive_scale = scale_out_r;

endmodule

>>> sv/slew_limit_gate_and_drive_scale.sv
// Top level of the slew limiter, steering gate and drive scale block.
// Instantiates slg_ctrl and slg_dp; depends on slg_pkg.
//
// Usage:
//   The input channel (in_valid/in_ready) takes one item: lateral and turn commands,
//   steering error, startup phase flag and restart flag. The output channel
//   (out_valid/out_ready) returns one result per item: both slew limited values,
//   the gate flag and the Q1.15 drive scale.
//   The cfg_ port writes one register per cycle with cfg_we; write only while idle.
//   One item is worked on at a time: the next item is accepted only after the result
//   of the last one has entered the output register. The drive scale comes from a
//   bit-serial restoring divider, which makes one quotient bit per cycle.
//   The output register parts the two sides: a new item is taken while a result waits;
//   if the receiver stalls, the finished item waits in the controller until the output
//   register frees up, and in_ready stays low meanwhile.
//   Reset (rst_n low, synchronous) clears the kept values and the configuration to
//   their reset values and empties the output register.
module slew_limit_gate_and_drive_scale (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [slg_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [slg_pkg::CFG_DATA_W-1:0] cfg_wdata,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic signed [15:0]             in_lateral_cmd,
  input  logic signed [15:0]             in_turn_cmd,
  input  logic signed [15:0]             in_steer_error,
  input  logic                           in_startup_phase,
  input  logic                           in_restart,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic signed [15:0]             out_lateral_out,
  output logic signed [15:0]             out_turn_out,
  output logic                           out_blocked,
  output logic [15:0]                    out_drive_scale
);

  slg_pkg::dp_cmd_t cmd;

  // Sequencer.
  slg_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .cmd       (cmd)
  );

  // Arithmetic and storage.
  slg_dp u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata),
    .cmd              (cmd),
    .in_lateral_cmd   (in_lateral_cmd),
    .in_turn_cmd      (in_turn_cmd),
    .in_steer_error   (in_steer_error),
    .in_startup_phase (in_startup_phase),
    .in_restart       (in_restart),
    .out_lateral_out  (out_lateral_out),
    .out_turn_out     (out_turn_out),
    .out_blocked      (out_blocked),
    .out_drive_scale  (out_drive_scale)
  );

endmodule

>>> sv/slg_chk.sv
// Port-level checker for the slew limiter block, bound to the top level.
// Depends on the top level's ports only.
module slg_chk (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [15:0] out_lateral_out,
  input logic [15:0] out_turn_out,
  input logic        out_blocked,
  input logic [15:0] out_drive_scale
);

  // A stalled result stays offered.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  // A stalled result keeps its payload.
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_lateral_out) && $stable(out_turn_out)
                                && $stable(out_blocked) && $stable(out_drive_scale))
    else $error("result payload changed while stalled");

  // Only one item is in work: ready drops right after an item is taken.
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("second item accepted while busy");

  // No result appears in the cycle after an item is taken unless one was already waiting.
  a_no_early: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && (!out_valid || out_ready) |=> !out_valid)
    else $error("result appeared too early");

  // Reset empties the output register.
  a_reset: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("output valid after reset");

endmodule

bind slew_limit_gate_and_drive_scale slg_chk u_slg_chk (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_valid),
  .in_ready        (in_ready),
  .out_valid       (out_valid),
  .out_ready       (out_ready),
  .out_lateral_out (out_lateral_out),
  .out_turn_out    (out_turn_out),
  .out_blocked     (out_blocked),
  .out_drive_scale (out_drive_scale)
);

>>> tb/slg_checker.sv
`timescale 1ns / 100ps
// Checker for slew_limit_gate_and_drive_scale: mirrors the registers and the kept values,
// predicts each result from the accepted items and compares it at the output channel.
// Depends on slg_pkg.
module slg_checker (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [slg_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [slg_pkg::CFG_DATA_W-1:0] cfg_wdata,
  input  logic                           in_valid,
  input  logic                           in_ready,
  input  logic signed [15:0]             in_lateral_cmd,
  input  logic signed [15:0]             in_turn_cmd,
  input  logic signed [15:0]             in_steer_error,
  input  logic                           in_startup_phase,
  input  logic                           in_restart,
  input  logic                           out_valid,
  input  logic                           out_ready,
  input  logic signed [15:0]             out_lateral_out,
  input  logic signed [15:0]             out_turn_out,
  input  logic                           out_blocked,
  input  logic [15:0]                    out_drive_scale,
  output int                             mismatches,
  output int                             pending
);

  typedef struct packed {
    logic signed [15:0] lateral;
    logic signed [15:0] turn;
    logic               blocked;
    logic [15:0]        scale;
  } drive_result_t;

  // Mirrored registers and kept values.
  logic [14:0]        lat_step;
  logic [14:0]        turn_step;
  logic signed [15:0] start_level;
  logic signed [15:0] run_level;
  logic [14:0]        full_scale;
  logic               scale_en;
  logic signed [15:0] kept_lateral;
  logic signed [15:0] kept_turn;

  drive_result_t expected_drives[$];
  int            reported = 0;

  // Move the kept value toward the command by at most the step limit.
  function automatic logic signed [15:0] slew_toward(input logic signed [15:0] kept,
                                                     input logic signed [15:0] cmd,
                                                     input logic [14:0]        limit);
    logic signed [16:0] wide_kept;
    logic signed [16:0] diff;
    logic signed [16:0] lim;
    logic signed [16:0] moved;
    wide_kept = {kept[15], kept};
    diff      = {cmd[15], cmd} - wide_kept;
    lim       = {2'b00, limit};
    if (diff <= lim && diff >= -lim) begin
      return cmd;
    end
    moved = (diff > 0) ? wide_kept + lim : wide_kept - lim;
    return moved[15:0];
  endfunction

  // Q1.15 drive scale 1 - err/full_scale, clamped to 0..1 and truncated.
  function automatic logic [15:0] drive_scale_for(input logic signed [15:0] err);
    logic [15:0] span;
    logic [31:0] scaled;
    span = (full_scale == '0) ? 16'd1 : {1'b0, full_scale};
    if (err <= 16'sd0) begin
      return slg_pkg::SCALE_ONE;
    end
    if ({1'b0, err[14:0]} >= span) begin
      return 16'd0;
    end
    scaled = {16'd0, span - {1'b0, err[14:0]}} << 15;
    return 16'(scaled / {16'd0, span});
  endfunction

  // Track registers and items, predict on input, compare on output.
  always @(posedge clk) begin : track
    drive_result_t      want;
    drive_result_t      got;
    logic signed [15:0] base_lateral;
    logic signed [15:0] base_turn;
    logic signed [15:0] threshold;
    if (!rst_n) begin
      lat_step     <= '0;
      turn_step    <= '0;
      start_level  <= '0;
      run_level    <= '0;
      full_scale   <= slg_pkg::FULL_SCALE_RST;
      scale_en     <= 1'b0;
      kept_lateral <= '0;
      kept_turn    <= '0;
      expected_drives.delete();
      mismatches   <= 0;
      pending      <= 0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          slg_pkg::REG_LAT_STEP:    lat_step    <= cfg_wdata[14:0];
          slg_pkg::REG_TURN_STEP:   turn_step   <= cfg_wdata[14:0];
          slg_pkg::REG_START_LEVEL: start_level <= cfg_wdata;
          slg_pkg::REG_RUN_LEVEL:   run_level   <= cfg_wdata;
          slg_pkg::REG_FULL_SCALE:  full_scale  <= cfg_wdata[14:0];
          slg_pkg::REG_SCALE_EN:    scale_en    <= cfg_wdata[0];
          default: ;
        endcase
      end

      // Compare a delivered result with the oldest prediction.
      if (out_valid && out_ready) begin
        got = {out_lateral_out, out_turn_out, out_blocked, out_drive_scale};
        if (expected_drives.size() == 0) begin
          mismatches <= mismatches + 1;
          if (reported < 10) begin
            $display("%0t: result with nothing expected: lat=%0d turn=%0d blk=%0b scale=%0d",
                     $time, got.lateral, got.turn, got.blocked, got.scale);
            reported++;
          end
        end else begin
          want = expected_drives.pop_front();
          if (got.lateral !== want.lateral || got.turn !== want.turn ||
              got.blocked !== want.blocked || got.scale !== want.scale) begin
            mismatches <= mismatches + 1;
            if (reported < 10) begin
              $display("%0t: mismatch expected lat=%0d turn=%0d blk=%0b scale=%0d", $time,
                       want.lateral, want.turn, want.blocked, want.scale);
              $display("%0t:          actual   lat=%0d turn=%0d blk=%0b scale=%0d", $time,
                       got.lateral, got.turn, got.blocked, got.scale);
              reported++;
            end
          end
        end
      end

      // Predict the result of an accepted item and update the kept values.
      if (in_valid && in_ready) begin
        base_lateral = in_restart ? 16'sd0 : kept_lateral;
        base_turn    = in_restart ? 16'sd0 : kept_turn;
        threshold    = in_startup_phase ? start_level : run_level;
        want.lateral = slew_toward(base_lateral, in_lateral_cmd, lat_step);
        want.turn    = slew_toward(base_turn, in_turn_cmd, turn_step);
        want.blocked = in_steer_error > threshold;
        if (want.blocked) begin
          want.scale = 16'd0;
        end else if (scale_en) begin
          want.scale = drive_scale_for(in_steer_error);
        end else begin
          want.scale = slg_pkg::SCALE_ONE;
        end
        kept_lateral <= want.lateral;
        kept_turn    <= want.turn;
        expected_drives.push_back(want);
      end

      pending <= expected_drives.size();
    end
  end

endmodule

>>> tb/testbench.sv
`timescale 1ns / 100ps
// Top of the testbench for slew_limit_gate_and_drive_scale: clock, reset, register
// writes, directed and random items, receiver back pressure and the final verdict.
// Depends on slg_pkg, the block and slg_checker.
module testbench;

  localparam int WATCHDOG_CYCLES = 2000;
  localparam int HOLDOFF_CYCLES  = 80;
  localparam int END_CYCLES      = 40;
  localparam int IDLE_PERCENT    = 28;
  localparam int PHASE_ITEMS     = 105;

  // Indexes with no register behind them.
  localparam logic [slg_pkg::CFG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
  localparam logic [slg_pkg::CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

  logic                           clk = 1'b0;
  logic                           rst_n;
  logic                           cfg_we;
  logic [slg_pkg::CFG_IDX_W-1:0]  cfg_index;
  logic [slg_pkg::CFG_DATA_W-1:0] cfg_wdata;
  logic                           in_valid;
  logic                           in_ready;
  logic signed [15:0]             in_lateral_cmd;
  logic signed [15:0]             in_turn_cmd;
  logic signed [15:0]             in_steer_error;
  logic                           in_startup_phase;
  logic                           in_restart;
  logic                           out_valid;
  logic                           out_ready;
  logic signed [15:0]             out_lateral_out;
  logic signed [15:0]             out_turn_out;
  logic                           out_blocked;
  logic [15:0]                    out_drive_scale;

  int                 fail_count;
  int                 pending;
  int                 quiet_cycles = 0;
  logic               idle_on = 1'b1;
  logic               hold_req = 1'b0;
  logic [14:0]        cur_full_scale = slg_pkg::FULL_SCALE_RST;
  logic signed [15:0] target_lateral = '0;
  logic signed [15:0] target_turn = '0;
  int                 hold_left = 0;

  slew_limit_gate_and_drive_scale dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_lateral_cmd   (in_lateral_cmd),
    .in_turn_cmd      (in_turn_cmd),
    .in_steer_error   (in_steer_error),
    .in_startup_phase (in_startup_phase),
    .in_restart       (in_restart),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_lateral_out  (out_lateral_out),
    .out_turn_out     (out_turn_out),
    .out_blocked      (out_blocked),
    .out_drive_scale  (out_drive_scale)
  );

  slg_checker u_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_lateral_cmd   (in_lateral_cmd),
    .in_turn_cmd      (in_turn_cmd),
    .in_steer_error   (in_steer_error),
    .in_startup_phase (in_startup_phase),
    .in_restart       (in_restart),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_lateral_out  (out_lateral_out),
    .out_turn_out     (out_turn_out),
    .out_blocked      (out_blocked),
    .out_drive_scale  (out_drive_scale),
    .mismatches       (fail_count),
    .pending          (pending)
  );

  // 12 ns clock.
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Watchdog: end the run when neither channel moves for too long.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_CYCLES) begin
      $display("[slew_limit_gate_and_drive_scale] ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Receiver: random stalls, plus one long hold-off when asked for.
  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_ready = 1'b0;
        repeat (HOLDOFF_CYCLES) @(negedge clk);
        hold_req = 1'b0;
      end
      out_ready = !idle_on || ($urandom_range(99, 0) >= IDLE_PERCENT);
    end
  end

  // Offer one item, with an occasional gap ahead of it, and wait until it is taken.
  task automatic send_item(input logic signed [15:0] lat, input logic signed [15:0] turn,
                           input logic signed [15:0] err, input logic startup,
                           input logic restart);
    if (idle_on && $urandom_range(99, 0) < IDLE_PERCENT) begin
      in_valid = 1'b0;
      repeat ($urandom_range(3, 1)) @(negedge clk);
    end
    in_valid         = 1'b1;
    in_lateral_cmd   = lat;
    in_turn_cmd      = turn;
    in_steer_error   = err;
    in_startup_phase = startup;
    in_restart       = restart;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
  endtask

  // Stop offering and wait until every predicted result has come back.
  task automatic drain();
    in_valid = 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  task automatic write_reg(input logic [slg_pkg::CFG_IDX_W-1:0] idx,
                           input logic [15:0] data);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_wdata = data;
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  // Write every register, and junk to the unused indexes.
  task automatic load_settings(input logic [15:0] lat_step, input logic [15:0] turn_step,
                               input logic [15:0] start_lvl, input logic [15:0] run_lvl,
                               input logic [15:0] fscale, input logic [15:0] enable);
    write_reg(slg_pkg::REG_LAT_STEP, lat_step);
    write_reg(slg_pkg::REG_TURN_STEP, turn_step);
    write_reg(REG_SPARE_LO, 16'($urandom));
    write_reg(slg_pkg::REG_START_LEVEL, start_lvl);
    write_reg(slg_pkg::REG_RUN_LEVEL, run_lvl);
    write_reg(slg_pkg::REG_FULL_SCALE, fscale);
    write_reg(slg_pkg::REG_SCALE_EN, enable);
    write_reg(REG_SPARE_HI, 16'($urandom));
  endtask

  // Step limit: zero, largest, small or any, always with a random unused top bit.
  function automatic logic [15:0] pick_step();
    logic [15:0] v;
    case ($urandom_range(5, 0))
      0:       v = 16'd0;
      1:       v = 16'h7FFF;
      2, 3:    v = 16'($urandom_range(64, 1));
      default: v = 16'($urandom);
    endcase
    v[15] = 1'($urandom_range(1, 0));
    return v;
  endfunction

  function automatic logic [15:0] pick_full_scale();
    logic [15:0] v;
    case ($urandom_range(6, 0))
      0:       v = 16'd0;
      1:       v = 16'd1;
      2:       v = 16'h7FFF;
      3, 4:    v = 16'($urandom_range(2000, 2));
      default: v = 16'($urandom);
    endcase
    v[15] = 1'($urandom_range(1, 0));
    return v;
  endfunction

  // Gate level: extremes, inside the scaling range, slightly negative or any.
  function automatic logic [15:0] pick_level();
    case ($urandom_range(6, 0))
      0:       return 16'h8000;
      1:       return 16'h7FFF;
      2, 3:    return 16'($urandom_range(cur_full_scale, 0));
      4:       return 16'(-$urandom_range(64, 1));
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [15:0] pick_command();
    case ($urandom_range(5, 0))
      0:       return 16'h8000;
      1:       return 16'h7FFF;
      2, 3:    return 16'($urandom_range(1024, 0) - 512);
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [15:0] pick_error();
    case ($urandom_range(9, 0))
      0, 1, 2, 3: return 16'($urandom_range(cur_full_scale, 0));
      4:          return 16'h8000;
      5:          return 16'h7FFF;
      6:          return 16'($urandom_range(2, 0) - 1);
      default:    return 16'($urandom);
    endcase
  endfunction

  task automatic random_settings();
    logic [15:0] fscale;
    fscale = pick_full_scale();
    cur_full_scale = fscale[14:0];
    load_settings(pick_step(), pick_step(), pick_level(), pick_level(), fscale,
                  16'($urandom));
  endtask

  // Commands are held for runs of items so the kept values settle, with some noise.
  task automatic random_items(input int count);
    logic signed [15:0] lat;
    logic signed [15:0] turn;
    for (int i = 0; i < count; i++) begin
      if (hold_left == 0) begin
        target_lateral = pick_command();
        target_turn    = pick_command();
        hold_left      = $urandom_range(16, 1);
      end
      hold_left--;
      lat  = target_lateral;
      turn = target_turn;
      if ($urandom_range(9, 0) == 0) begin
        lat = 16'($urandom);
      end
      if ($urandom_range(9, 0) == 0) begin
        turn = 16'($urandom);
      end
      send_item(lat, turn, pick_error(), 1'($urandom_range(1, 0)),
                $urandom_range(19, 0) == 0);
    end
  endtask

  // Reset, directed items, random phases and the verdict.
  initial begin
    rst_n            = 1'b0;
    cfg_we           = 1'b0;
    cfg_index        = '0;
    cfg_wdata        = '0;
    in_valid         = 1'b0;
    in_lateral_cmd   = '0;
    in_turn_cmd      = '0;
    in_steer_error   = '0;
    in_startup_phase = 1'b0;
    in_restart       = 1'b0;
    repeat (7) @(negedge clk);
    rst_n = 1'b1;

    // Reset settings: zero step limits hold the kept values at zero.
    send_item(16'sh0000, 16'sh0000, 16'sh0000, 1'b0, 1'b0);
    send_item(16'sh7FFF, 16'sh8000, 16'sh0001, 1'b0, 1'b0);
    send_item(16'sh0001, 16'sh0000, 16'shFFFF, 1'b1, 1'b0);

    // Top lateral step and full scale, turn step 1, extreme levels, excess bits.
    drain();
    load_settings(16'hFFFF, 16'h8001, 16'h8000, 16'h7FFF, 16'hFFFF, 16'hFFFF);
    send_item(16'sh7FFF, 16'sh7FFF, 16'sh8000, 1'b0, 1'b0);
    send_item(16'sh8000, 16'sh8000, 16'sh7FFF, 1'b0, 1'b0);
    send_item(16'sh8000, 16'sh8000, 16'sh0001, 1'b0, 1'b0);
    send_item(16'sh8000, 16'sh0000, 16'sh8000, 1'b1, 1'b0);
    send_item(16'sh8000, 16'sh0000, 16'sh8001, 1'b1, 1'b0);
    send_item(16'sh0064, 16'sh0064, 16'sh0000, 1'b1, 1'b1);
    send_item(16'sh0064, 16'sh0064, 16'sh3FFF, 1'b0, 1'b0);

    // Zero lateral step, full scale of one.
    drain();
    load_settings(16'h8000, 16'hFFFF, 16'h7FFF, 16'h8000, 16'h0001, 16'h0001);
    send_item(16'sh7FFF, 16'sh7FFF, 16'sh0001, 1'b0, 1'b0);
    send_item(16'sh7FFF, 16'sh7FFF, 16'sh8000, 1'b0, 1'b0);
    send_item(16'sh0000, 16'sh8000, 16'sh0000, 1'b1, 1'b0);
    send_item(16'sh0000, 16'sh8000, 16'sh0001, 1'b1, 1'b0);

    // Scaling disabled; gate levels near the error.
    drain();
    load_settings(16'h0100, 16'h0100, 16'h0000, 16'h0064, 16'h8000, 16'h0002);
    send_item(16'sh7FFF, 16'sh8000, 16'sh0005, 1'b0, 1'b0);
    send_item(16'sh7FFF, 16'sh8000, 16'sh0065, 1'b0, 1'b0);
    send_item(16'sh0000, 16'sh0000, 16'sh0032, 1'b1, 1'b1);

    // Zero full scale behaves as one.
    drain();
    load_settings(16'h0100, 16'h0100, 16'h7FFF, 16'h7FFF, 16'h8000, 16'h0001);
    send_item(16'sh0000, 16'sh0000, 16'sh0001, 1'b0, 1'b0);
    send_item(16'sh0000, 16'sh0000, 16'sh0000, 1'b0, 1'b0);
    send_item(16'sh0000, 16'sh0000, 16'shFFFB, 1'b1, 1'b0);

    // Random phases; one runs without idling, one starts with a long receiver stall.
    for (int phase = 0; phase < 8; phase++) begin
      drain();
      random_settings();
      idle_on = (phase != 3);
      if (phase == 5) begin
        hold_req = 1'b1;
      end
      random_items(PHASE_ITEMS);
    end

    drain();
    repeat (END_CYCLES) @(negedge clk);
    if (fail_count == 0) begin
      $display("[slew_limit_gate_and_drive_scale] OK");
    end else begin
      $display("[slew_limit_gate_and_drive_scale] ERROR");
    end
    $finish;
  end

endmodule
